### hdl/php_pkg.sv
package php_pkg;

	typedef enum logic [2:0] {
		PH_LINK    = 3'd0,
		PH_VLAN    = 3'd1,
		PH_IP      = 3'd2,
		PH_TCP     = 3'd3,
		PH_UDP     = 3'd4,
		PH_PAYLOAD = 3'd5,
		PH_DONE    = 3'd6
	} phase_t;

	typedef enum logic [2:0] {
		ST_OK       = 3'd0,
		ST_TRUNC    = 3'd1,
		ST_NOT_IPV4 = 3'd2,
		ST_BAD_IP   = 3'd3,
		ST_FRAG     = 3'd4,
		ST_NOT_L4   = 3'd5,
		ST_BAD_TCP  = 3'd6
	} status_t;

	localparam logic [15:0] ETH_VLAN_CTAG = 16'h8100;
	localparam logic [15:0] ETH_VLAN_STAG = 16'h88A8;
	localparam logic [15:0] ETH_IPV4      = 16'h0800;
	localparam logic [15:0] FRAG_OFS_MASK = 16'h1FFF;
	localparam logic [15:0] COUNT_MAX     = 16'hFFFF;
	localparam logic [7:0]  PROTO_TCP     = 8'd6;
	localparam logic [7:0]  PROTO_UDP     = 8'd17;
	localparam logic [3:0]  IP_VERSION4   = 4'd4;
	localparam logic [15:0] ETH_TYPE_POS  = 16'd13;
	localparam logic [15:0] SLL_PROTO_POS = 16'd15;
	localparam logic [6:0]  UDP_HDR_LEN   = 7'd8;
	localparam logic [6:0]  MIN_HDR_LEN   = 7'd20;

endpackage

### hdl/php_if.sv
interface php_byte_if;
	logic       valid;
	logic       ready;
	logic [7:0] frame_byte;
	logic       last_byte;

	modport source (output valid, output frame_byte, output last_byte, input ready);
	modport sink (input valid, input frame_byte, input last_byte, output ready);
endinterface

interface php_result_if;
	logic        valid;
	logic        ready;
	logic [2:0]  status;
	logic [7:0]  l4_protocol;
	logic [31:0] source_address;
	logic [31:0] dest_address;
	logic [15:0] source_port;
	logic [15:0] dest_port;
	logic [7:0]  flag_bits;
	logic [15:0] payload_offset;
	logic [15:0] payload_length;

	modport source (output valid, output status, output l4_protocol, output source_address,
		output dest_address, output source_port, output dest_port, output flag_bits,
		output payload_offset, output payload_length, input ready);
	modport sink (input valid, input status, input l4_protocol, input source_address,
		input dest_address, input source_port, input dest_port, input flag_bits,
		input payload_offset, input payload_length, output ready);
endinterface

### hdl/packet_header_parser.sv
// A result passes through the snapshot register, loaded on the transfer of a frame's last
// byte, then the result register, loaded from it when empty or when its result is taken.
// Throughput: one frame byte per cycle; input stalls only while both the snapshot and
// the result register hold finished frames and the result is not being taken. A new
// frame may start right after a last byte.
// Reset (arst_n low) clears link_type, all frame state and both valid flags at once.
module packet_header_parser (
	input  logic         clk,
	input  logic         arst_n,
	input  logic         cfg_we,
	input  logic         cfg_wdata,
	php_byte_if.sink     in_ch,
	php_result_if.source out_ch
);
	import php_pkg::*;

	logic link_type_q;

	// frame state
	logic [15:0] bc_q, bc_n;
	phase_t      ph_q, ph_n;
	logic [15:0] hs_q, hs_n;
	logic [15:0] ek_q, ek_n;
	logic [5:0]  ihl_q, ihl_n;
	logic [15:0] tot_q, tot_n;
	logic [15:0] frag_q, frag_n;
	logic [7:0]  proto_q, proto_n;
	logic [31:0] src_q, src_n;
	logic [31:0] dst_q, dst_n;
	logic [15:0] sp_q, sp_n;
	logic [15:0] dp_q, dp_n;
	logic [7:0]  flags_q, flags_n;
	logic [6:0]  l4len_q, l4len_n;
	status_t     err_q, err_n;

	logic [7:0]  b;
	logic [15:0] pos, rel, pos_inc;
	logic        link_end, tags_ok;
	logic        in_fire;

	// end-of-frame snapshot stage
	logic        snap_valid_s1;
	status_t     status_s1;
	logic [7:0]  proto_s1;
	logic [31:0] src_s1, dst_s1;
	logic [15:0] sp_s1, dp_s1;
	logic [7:0]  flags_s1;
	logic [15:0] ofs_s1, cap_s1, tot_s1;
	logic [5:0]  ihl_s1;
	logic [6:0]  l4len_s1;
	logic        snap_adv;

	logic signed [17:0] decl;
	logic [15:0]        decl_clamp, pay_len;

	assign b       = in_ch.frame_byte;
	assign pos     = bc_q;
	assign rel     = bc_q - hs_q;
	assign pos_inc = bc_q + 16'd1;
	assign in_fire = in_ch.valid && in_ch.ready;

	assign snap_adv    = !out_ch.valid || out_ch.ready;
	assign in_ch.ready = !snap_valid_s1 || snap_adv;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			link_type_q <= 1'b0;
		end else if (cfg_we) begin
			link_type_q <= cfg_wdata;
		end
	end

	always_comb begin
		bc_n = bc_q; ph_n = ph_q; hs_n = hs_q; ek_n = ek_q; ihl_n = ihl_q;
		tot_n = tot_q; frag_n = frag_q; proto_n = proto_q; src_n = src_q;
		dst_n = dst_q; sp_n = sp_q; dp_n = dp_q; flags_n = flags_q;
		l4len_n = l4len_q; err_n = err_q;
		link_end = 1'b0;
		tags_ok = 1'b0;
		if (bc_q != COUNT_MAX) begin
			bc_n = pos_inc;
			unique case (ph_q)
				PH_LINK, PH_VLAN: begin
					ek_n = {ek_q[7:0], b};
					if (ph_q == PH_VLAN) begin
						link_end = (rel == 16'd3);
						tags_ok  = 1'b1;
					end else if (!link_type_q) begin
						link_end = (pos == ETH_TYPE_POS);
						tags_ok  = 1'b1;
					end else begin
						link_end = (pos == SLL_PROTO_POS);
					end
					if (link_end) begin
						hs_n = pos_inc;
						priority if (tags_ok && (ek_n == ETH_VLAN_CTAG || ek_n == ETH_VLAN_STAG)) begin
							ph_n = PH_VLAN;
						end else if (ek_n == ETH_IPV4) begin
							ph_n = PH_IP;
						end else begin
							err_n = ST_NOT_IPV4;
							ph_n  = PH_DONE;
						end
					end
				end
				PH_IP: begin
					priority if (rel == 16'd0) begin
						ihl_n = {b[3:0], 2'b00};
						if (b[7:4] != IP_VERSION4 || {1'b0, ihl_n} < MIN_HDR_LEN)
							err_n = ST_BAD_IP;
					end else if (rel == 16'd2 || rel == 16'd3) begin
						tot_n = {tot_q[7:0], b};
					end else if (rel == 16'd6 || rel == 16'd7) begin
						frag_n = {frag_q[7:0], b};
					end else if (rel == 16'd9) begin
						proto_n = b;
					end else if (rel >= 16'd12 && rel <= 16'd15) begin
						src_n = {src_q[23:0], b};
					end else if (rel >= 16'd16 && rel <= 16'd19) begin
						dst_n = {dst_q[23:0], b};
					end else begin
						// unused header bytes and options: skip
					end
					priority if (rel == 16'd19 && err_n != ST_OK) begin
						ph_n = PH_DONE;
					end else if (rel >= 16'd19 && ({1'b0, rel} + 17'd1) == {11'd0, ihl_n}) begin
						priority if (tot_n < {10'd0, ihl_n}) begin
							err_n = ST_BAD_IP;
							ph_n  = PH_DONE;
						end else if ((frag_n & FRAG_OFS_MASK) != 16'd0) begin
							err_n = ST_FRAG;
							ph_n  = PH_DONE;
						end else if (proto_n == PROTO_TCP) begin
							ph_n = PH_TCP;
							hs_n = pos_inc;
						end else if (proto_n == PROTO_UDP) begin
							ph_n = PH_UDP;
							hs_n = pos_inc;
						end else begin
							err_n = ST_NOT_L4;
							ph_n  = PH_DONE;
						end
					end else begin
						// keep reading the header
					end
				end
				PH_TCP, PH_UDP: begin
					priority if (rel <= 16'd1) begin
						sp_n = {sp_q[7:0], b};
					end else if (rel <= 16'd3) begin
						dp_n = {dp_q[7:0], b};
					end else if (ph_q == PH_TCP && rel == 16'd12) begin
						l4len_n = {1'b0, b[7:4], 2'b00};
					end else if (ph_q == PH_TCP && rel == 16'd13) begin
						flags_n = b;
					end else begin
						// skip
					end
					if (ph_q == PH_UDP) begin
						if (rel == 16'd7) begin
							l4len_n = UDP_HDR_LEN;
							ph_n    = PH_PAYLOAD;
							hs_n    = pos_inc;
						end
					end else begin
						priority if (rel == 16'd19 && l4len_n < MIN_HDR_LEN) begin
							err_n = ST_BAD_TCP;
							ph_n  = PH_DONE;
						end else if (rel >= 16'd19 && ({1'b0, rel} + 17'd1) == {10'd0, l4len_n}) begin
							ph_n = PH_PAYLOAD;
							hs_n = pos_inc;
						end else begin
							// keep reading the header
						end
					end
				end
				default: begin
					// payload or done: count only
				end
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			bc_q <= '0; ph_q <= PH_LINK; hs_q <= '0; ek_q <= '0; ihl_q <= '0;
			tot_q <= '0; frag_q <= '0; proto_q <= '0; src_q <= '0; dst_q <= '0;
			sp_q <= '0; dp_q <= '0; flags_q <= '0; l4len_q <= '0; err_q <= ST_OK;
		end else if (in_fire) begin
			if (in_ch.last_byte) begin
				// clear for the next frame
				bc_q <= '0; ph_q <= PH_LINK; hs_q <= '0; ek_q <= '0; ihl_q <= '0;
				tot_q <= '0; frag_q <= '0; proto_q <= '0; src_q <= '0; dst_q <= '0;
				sp_q <= '0; dp_q <= '0; flags_q <= '0; l4len_q <= '0; err_q <= ST_OK;
			end else begin
				bc_q <= bc_n; ph_q <= ph_n; hs_q <= hs_n; ek_q <= ek_n; ihl_q <= ihl_n;
				tot_q <= tot_n; frag_q <= frag_n; proto_q <= proto_n; src_q <= src_n;
				dst_q <= dst_n; sp_q <= sp_n; dp_q <= dp_n; flags_q <= flags_n;
				l4len_q <= l4len_n; err_q <= err_n;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			snap_valid_s1 <= 1'b0;
		end else if (in_fire && in_ch.last_byte) begin
			snap_valid_s1 <= 1'b1;
		end else if (snap_adv) begin
			snap_valid_s1 <= 1'b0;
		end
	end

	// snapshot the finished frame; non-ok results carry zero fields
	always_ff @(posedge clk) begin
		if (in_fire && in_ch.last_byte) begin
			status_s1 <= (ph_n == PH_PAYLOAD) ? ST_OK :
				(ph_n == PH_DONE) ? err_n : ST_TRUNC;
			if (ph_n == PH_PAYLOAD) begin
				proto_s1 <= proto_n; src_s1 <= src_n; dst_s1 <= dst_n;
				sp_s1 <= sp_n; dp_s1 <= dp_n; flags_s1 <= flags_n;
				ofs_s1 <= hs_n; cap_s1 <= bc_n - hs_n;
				tot_s1 <= tot_n; ihl_s1 <= ihl_n; l4len_s1 <= l4len_n;
			end else begin
				proto_s1 <= '0; src_s1 <= '0; dst_s1 <= '0; sp_s1 <= '0; dp_s1 <= '0;
				flags_s1 <= '0; ofs_s1 <= '0; cap_s1 <= '0;
				tot_s1 <= '0; ihl_s1 <= '0; l4len_s1 <= '0;
			end
		end
	end

	assign decl = $signed({2'b00, tot_s1}) - $signed({12'd0, ihl_s1})
		- $signed({11'd0, l4len_s1});
	assign decl_clamp = decl[17] ? 16'd0 : decl[15:0];
	assign pay_len    = (decl_clamp < cap_s1) ? decl_clamp : cap_s1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_ch.valid <= 1'b0;
		end else if (snap_adv) begin
			out_ch.valid <= snap_valid_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (snap_adv && snap_valid_s1) begin
			out_ch.status         <= status_s1;
			out_ch.l4_protocol    <= proto_s1;
			out_ch.source_address <= src_s1;
			out_ch.dest_address   <= dst_s1;
			out_ch.source_port    <= sp_s1;
			out_ch.dest_port      <= dp_s1;
			out_ch.flag_bits      <= flags_s1;
			out_ch.payload_offset <= ofs_s1;
			out_ch.payload_length <= pay_len;
		end
	end

endmodule

### hdl/php_checker.sv
module php_checker (
	input logic        clk,
	input logic        arst_n,
	input logic        out_valid,
	input logic        out_ready,
	input logic [2:0]  status,
	input logic [7:0]  l4_protocol,
	input logic [31:0] source_address,
	input logic [31:0] dest_address,
	input logic [15:0] source_port,
	input logic [15:0] dest_port,
	input logic [7:0]  flag_bits,
	input logic [15:0] payload_offset,
	input logic [15:0] payload_length
);
	import php_pkg::*;

	// hold a stalled result
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid && $stable(status) && $stable(payload_length))
		else $error("result changed while stalled");

	a_status_range: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> status <= ST_BAD_TCP)
		else $error("status code out of range");

	a_fail_zero: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && status != ST_OK |-> l4_protocol == 8'd0 && source_address == 32'd0 &&
			dest_address == 32'd0 && source_port == 16'd0 && dest_port == 16'd0 &&
			flag_bits == 8'd0 && payload_offset == 16'd0 && payload_length == 16'd0)
		else $error("failed frame carries nonzero fields");

	a_ok_proto: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && status == ST_OK |-> l4_protocol == PROTO_TCP || l4_protocol == PROTO_UDP)
		else $error("ok frame with protocol other than TCP or UDP");

	a_udp_flags: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && status == ST_OK && l4_protocol == PROTO_UDP |-> flag_bits == 8'd0)
		else $error("UDP result with flags set");

endmodule

bind packet_header_parser php_checker u_php_checker (
	.clk            (clk),
	.arst_n         (arst_n),
	.out_valid      (out_ch.valid),
	.out_ready      (out_ch.ready),
	.status         (out_ch.status),
	.l4_protocol    (out_ch.l4_protocol),
	.source_address (out_ch.source_address),
	.dest_address   (out_ch.dest_address),
	.source_port    (out_ch.source_port),
	.dest_port      (out_ch.dest_port),
	.flag_bits      (out_ch.flag_bits),
	.payload_offset (out_ch.payload_offset),
	.payload_length (out_ch.payload_length)
);
